// File: rtl/packet_sampler_xorshift_macros.svh
// ----------------------------------------------------------------------------
// packet_sampler_xorshift_macros.svh
// Assertion macros shared by the sampler's checker.
// ----------------------------------------------------------------------------
`ifndef PACKET_SAMPLER_XORSHIFT_MACROS_SVH
`define PACKET_SAMPLER_XORSHIFT_MACROS_SVH

// Same-cycle implication, disabled while reset is high
`define PSS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high
`define PSS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/pss_pkg.sv
// ----------------------------------------------------------------------------
// pss_pkg
// Shared types, constants and functions of the xorshift packet sampler.
// ----------------------------------------------------------------------------
package pss_pkg;

   localparam int MaxCaptureBytesDef = 256;
   localparam int ExcludeSlotsDef    = 16;
   localparam int HwSlots            = 16;  // port entries held by the CSR block
   localparam int PortW              = 16;
   localparam int CapW               = 9;
   localparam int ThreshW            = 32;
   localparam int CountW             = 5;
   localparam int StateW             = 64;
   localparam int CsrAddrW           = 3;
   localparam int CsrDataW           = 64;
   localparam int VerdictW           = 3;

   typedef enum logic [VerdictW-1:0] {
      VERDICT_SAMPLED     = 3'd0,
      VERDICT_DISABLED    = 3'd1,
      VERDICT_EXCLUDED    = 3'd2,
      VERDICT_THRESH_ZERO = 3'd3,
      VERDICT_REJECTED    = 3'd4
   } verdict_type;

   typedef enum logic [CsrAddrW-1:0] {
      CSR_ENABLE     = 3'd0,
      CSR_THRESHOLD  = 3'd1,
      CSR_EXCL_COUNT = 3'd2,
      CSR_PORTS_LOW  = 3'd3,
      CSR_PORTS_MID  = 3'd4,
      CSR_PORTS_HIGH = 3'd5,
      CSR_PORTS_TOP  = 3'd6,
      CSR_SEED       = 3'd7
   } csr_addr_type;

   // Configuration seen by the datapath
   typedef struct packed {
      logic                             enabled;
      logic [ThreshW-1:0]               threshold;
      logic [CountW-1:0]                excl_count;
      logic [HwSlots-1:0][PortW-1:0]    excl_ports;
   } cfg_type;

   // Seed reload request toward the generator
   typedef struct packed {
      logic              load;
      logic [StateW-1:0] value;
   } seed_type;

   // One xorshift64 step, shifts 13 / 7 / 17
   function automatic logic [StateW-1:0] xorshift64(input logic [StateW-1:0] x);
      logic [StateW-1:0] a;
      logic [StateW-1:0] b;
      a = x ^ (x << 13);
      b = a ^ (a >> 7);
      return b ^ (b << 17);
   endfunction

endpackage

// File: rtl/pss_channels.sv
// ----------------------------------------------------------------------------
// pss_channels
// Valid/ready channel interfaces: packet request, sample response, CSR write.
// ----------------------------------------------------------------------------
interface pss_req_if;
   logic                     valid;
   logic                     ready;
   logic [pss_pkg::PortW-1:0] source_port;
   logic [pss_pkg::PortW-1:0] destination_port;
   logic [pss_pkg::PortW-1:0] packet_length;

   modport source (output valid, source_port, destination_port, packet_length,
                   input ready);
   modport sink   (input valid, source_port, destination_port, packet_length,
                   output ready);
endinterface

interface pss_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        take_sample;
   logic [pss_pkg::CapW-1:0]     capture_length;
   logic [pss_pkg::VerdictW-1:0] verdict_code;

   modport source (output valid, take_sample, capture_length, verdict_code,
                   input ready);
   modport sink   (input valid, take_sample, capture_length, verdict_code,
                   output ready);
endinterface

interface pss_csr_if;
   logic                        valid;
   logic                        ready;
   logic [pss_pkg::CsrAddrW-1:0] addr;
   logic [pss_pkg::CsrDataW-1:0] wdata;

   modport source (output valid, addr, wdata, input ready);
   modport sink   (input valid, addr, wdata, output ready);
endinterface

// File: rtl/pss_csr.sv
// ----------------------------------------------------------------------------
// pss_csr
// Configuration register file; a seed write also requests a generator reload.
// ----------------------------------------------------------------------------
module pss_csr (
   input  logic              clock,
   input  logic              reset,
   pss_csr_if.sink           csr_chan,
   output pss_pkg::cfg_type  cfg,
   output pss_pkg::seed_type seed
);
   import pss_pkg::*;

   logic                  enabled_ff,   enabled_in;
   logic [ThreshW-1:0]    threshold_ff, threshold_in;
   logic [CountW-1:0]     count_ff,     count_in;
   logic [3:0][CsrDataW-1:0] ports_ff,  ports_in;
   logic                  wr;
   csr_addr_type          addr;

   // Writes are always taken
   assign csr_chan.ready = 1'b1;
   assign wr   = csr_chan.valid;
   assign addr = csr_addr_type'(csr_chan.addr);

   // Register decode
   always_comb begin
      enabled_in   = enabled_ff;
      threshold_in = threshold_ff;
      count_in     = count_ff;
      ports_in     = ports_ff;
      if (wr) begin
         case (addr)
            CSR_ENABLE:     enabled_in   = csr_chan.wdata[0];
            CSR_THRESHOLD:  threshold_in = csr_chan.wdata[ThreshW-1:0];
            CSR_EXCL_COUNT: count_in     = csr_chan.wdata[CountW-1:0];
            CSR_PORTS_LOW:  ports_in[0]  = csr_chan.wdata;
            CSR_PORTS_MID:  ports_in[1]  = csr_chan.wdata;
            CSR_PORTS_HIGH: ports_in[2]  = csr_chan.wdata;
            CSR_PORTS_TOP:  ports_in[3]  = csr_chan.wdata;
            default: ;  // seed goes straight to the generator
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff   <= 1'b0;
         threshold_ff <= '0;
         count_ff     <= '0;
         ports_ff     <= '0;
      end else begin
         enabled_ff   <= enabled_in;
         threshold_ff <= threshold_in;
         count_ff     <= count_in;
         ports_ff     <= ports_in;
      end
   end

   assign cfg.enabled    = enabled_ff;
   assign cfg.threshold  = threshold_ff;
   assign cfg.excl_count = count_ff;
   assign cfg.excl_ports = ports_ff;

   assign seed.load  = wr && (addr == CSR_SEED);
   assign seed.value = csr_chan.wdata;

endmodule

// File: rtl/pss_gen.sv
// ----------------------------------------------------------------------------
// pss_gen
// xorshift64 state register with seed reload and one-step lookahead.
// ----------------------------------------------------------------------------
module pss_gen (
   input  logic                       clock,
   input  logic                       reset,
   input  pss_pkg::seed_type          seed,
   input  logic                       step,
   output logic [pss_pkg::StateW-1:0] rnd_next
);
   import pss_pkg::*;

   logic [StateW-1:0] state_ff, state_in;

   assign rnd_next = xorshift64(state_ff);

   // A zero seed loads one so the generator never sticks at zero
   always_comb begin
      state_in = state_ff;
      if (seed.load) begin
         state_in = (seed.value == '0) ? StateW'(1) : seed.value;
      end else if (step) begin
         state_in = rnd_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StateW'(1);
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: rtl/pss_judge.sv
// ----------------------------------------------------------------------------
// pss_judge
// Per-packet decision: enable, port exclusion, threshold, random compare.
// ----------------------------------------------------------------------------
module pss_judge #(
   parameter int MAX_CAPTURE_BYTES = pss_pkg::MaxCaptureBytesDef,
   parameter int EXCLUDE_SLOTS     = pss_pkg::ExcludeSlotsDef
) (
   input  pss_pkg::cfg_type            cfg,
   input  logic [pss_pkg::PortW-1:0]   sport,
   input  logic [pss_pkg::PortW-1:0]   dport,
   input  logic [pss_pkg::PortW-1:0]   len,
   input  logic [pss_pkg::StateW-1:0]  rnd_next,
   output logic                        step,
   output logic                        take,
   output logic [pss_pkg::CapW-1:0]    cap,
   output pss_pkg::verdict_type        verdict
);
   import pss_pkg::*;

   localparam int Slots = (EXCLUDE_SLOTS > HwSlots) ? HwSlots : EXCLUDE_SLOTS;
   localparam logic [PortW-1:0] MaxCap = PortW'(MAX_CAPTURE_BYTES);

   logic [Slots-1:0] hit;
   logic             excluded;
   logic [PortW-1:0] len_cap;

   // Parallel port compares; only the first excl_count entries count
   always_comb begin
      for (int i = 0; i < Slots; i++) begin
         hit[i] = (CountW'(i) < cfg.excl_count) &&
                  ((cfg.excl_ports[i] == sport) || (cfg.excl_ports[i] == dport));
      end
   end
   assign excluded = |hit;

   assign len_cap = (len > MaxCap) ? MaxCap : len;

   // First matching reason wins
   always_comb begin
      step    = 1'b0;
      take    = 1'b0;
      cap     = '0;
      verdict = VERDICT_SAMPLED;
      if (!cfg.enabled) begin
         verdict = VERDICT_DISABLED;
      end else if (excluded) begin
         verdict = VERDICT_EXCLUDED;
      end else if (cfg.threshold == '0) begin
         verdict = VERDICT_THRESH_ZERO;
      end else begin
         step = 1'b1;
         if (rnd_next[ThreshW-1:0] >= cfg.threshold) begin
            verdict = VERDICT_REJECTED;
         end else begin
            take = 1'b1;
            cap  = len_cap[CapW-1:0];
         end
      end
   end

endmodule

// File: rtl/packet_sampler_xorshift.sv
// ----------------------------------------------------------------------------
// packet_sampler_xorshift: random packet sampler with port exclusion
// A request passes the input register, then the result register, before its
// response is valid. One packet per cycle unless the response channel stalls,
// set by the combinational decide and generator update. Synchronous reset empties
// both stages and loads the generator with 1; CSR writes taken every cycle.
// ----------------------------------------------------------------------------
module packet_sampler_xorshift #(
   parameter int MAX_CAPTURE_BYTES = pss_pkg::MaxCaptureBytesDef,
   parameter int EXCLUDE_SLOTS     = pss_pkg::ExcludeSlotsDef
) (
   input  logic       clock,
   input  logic       reset,
   pss_req_if.sink    req_chan,
   pss_rsp_if.source  rsp_chan,
   pss_csr_if.sink    csr_chan
);
   import pss_pkg::*;

   cfg_type           cfg;
   seed_type          seed;
   logic [StateW-1:0] rnd_next;

   logic              s1_vld_ff, s1_vld_in;
   logic [PortW-1:0]  s1_sport_ff, s1_dport_ff, s1_len_ff;
   logic              out_vld_ff, out_vld_in;
   logic              out_take_ff;
   logic [CapW-1:0]   out_cap_ff;
   verdict_type       out_verdict_ff;

   logic              advance;
   logic              accept;
   logic              step;
   logic              take;
   logic [CapW-1:0]   cap;
   verdict_type       verdict;

   pss_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg),
      .seed     (seed)
   );

   pss_gen u_gen (
      .clock    (clock),
      .reset    (reset),
      .seed     (seed),
      .step     (advance && step),
      .rnd_next (rnd_next)
   );

   pss_judge #(
      .MAX_CAPTURE_BYTES (MAX_CAPTURE_BYTES),
      .EXCLUDE_SLOTS     (EXCLUDE_SLOTS)
   ) u_judge (
      .cfg      (cfg),
      .sport    (s1_sport_ff),
      .dport    (s1_dport_ff),
      .len      (s1_len_ff),
      .rnd_next (rnd_next),
      .step     (step),
      .take     (take),
      .cap      (cap),
      .verdict  (verdict)
   );

   // Pipeline flow: stage 1 moves on when the result register is empty or its response is taken
   assign advance        = s1_vld_ff && (!out_vld_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_vld_ff || advance;
   assign accept         = req_chan.valid && req_chan.ready;

   assign s1_vld_in  = accept || (s1_vld_ff && !advance);
   assign out_vld_in = advance || (out_vld_ff && !rsp_chan.ready);

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff  <= s1_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_sport_ff <= req_chan.source_port;
         s1_dport_ff <= req_chan.destination_port;
         s1_len_ff   <= req_chan.packet_length;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (advance) begin
         out_take_ff    <= take;
         out_cap_ff     <= cap;
         out_verdict_ff <= verdict;
      end
   end

   assign rsp_chan.valid          = out_vld_ff;
   assign rsp_chan.take_sample    = out_take_ff;
   assign rsp_chan.capture_length = out_cap_ff;
   assign rsp_chan.verdict_code   = out_verdict_ff;

endmodule

// File: rtl/pss_checker.sv
// ----------------------------------------------------------------------------
// pss_checker
// Port-level checks on the sampler's response channel, bound to the top.
// ----------------------------------------------------------------------------
`include "packet_sampler_xorshift_macros.svh"

module pss_checker #(
   parameter int MAX_CAPTURE_BYTES = pss_pkg::MaxCaptureBytesDef
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic                          take_sample,
   input logic [pss_pkg::CapW-1:0]      capture_length,
   input logic [pss_pkg::VerdictW-1:0]  verdict_code
);
   import pss_pkg::*;

   localparam logic [CapW:0] CapLimit =
      (MAX_CAPTURE_BYTES > 256) ? (CapW+1)'(256) : (CapW+1)'(MAX_CAPTURE_BYTES);

   // Stalled transaction keeps its contents
   `PSS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable({take_sample, capture_length, verdict_code}), "response changed while stalled")

   // Sample flag agrees with the verdict
   `PSS_ASSERT_NOW(a_take_verdict, clock, reset, rsp_valid, take_sample == (verdict_code == VERDICT_SAMPLED), "take_sample and verdict disagree")

   // Unsampled packets report no capture
   `PSS_ASSERT_NOW(a_cap_zero, clock, reset, rsp_valid && !take_sample, capture_length == '0, "capture length on unsampled packet")

   // Capture never exceeds the maximum
   `PSS_ASSERT_NOW(a_cap_max, clock, reset, rsp_valid && take_sample, {1'b0, capture_length} <= CapLimit, "capture length above maximum")

   // Verdict is a defined code
   `PSS_ASSERT_NOW(a_verdict_code, clock, reset, rsp_valid, verdict_code <= VERDICT_REJECTED, "undefined verdict code")

endmodule

bind packet_sampler_xorshift pss_checker #(
   .MAX_CAPTURE_BYTES (MAX_CAPTURE_BYTES)
) u_pss_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .take_sample    (rsp_chan.take_sample),
   .capture_length (rsp_chan.capture_length),
   .verdict_code   (rsp_chan.verdict_code)
);
